// File: rtl/ear_clipping_triangulator_core_defines.svh
// Assertion macros shared by the checker of the ear clipping core.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef EAR_CLIPPING_TRIANGULATOR_CORE_DEFINES_SVH
`define EAR_CLIPPING_TRIANGULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ECT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ear clipping core: property failed");

// Next-cycle implication, disabled while reset is asserted
`define ECT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ear clipping core: property failed");

`endif

// File: rtl/ectri_pkg.sv
// Shared constants, types and status codes of the ear clipping core.
// Depends on nothing.
`default_nettype none
package ectri_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = 17;
	localparam int PROD_W       = 34;
	localparam int CROSS_W      = 35;
	localparam int SUM_W        = 36;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NO_EAR = 2'd1;
	localparam logic [1:0] ST_FEW    = 2'd2;
	localparam logic [1:0] ST_OVF    = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vtx_t;

	typedef struct packed {
		vtx_t       a;
		vtx_t       b;
		vtx_t       c;
		logic       has_tri;
		logic [1:0] status;
		logic       last;
	} res_t;
endpackage
`default_nettype wire

// File: rtl/ectri_turn.sv
// Three-stage orientation unit: sign of the cross product at corner b.
// Depends on ectri_pkg.
`default_nettype none
module ectri_turn (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  ectri_pkg::vtx_t  a,
	input  ectri_pkg::vtx_t  b,
	input  ectri_pkg::vtx_t  c,
	output logic             done,
	output logic             neg
);
	logic signed [ectri_pkg::DIFF_W-1:0] dux_s1, duy_s1, dvx_s1, dvy_s1;
	logic signed [ectri_pkg::PROD_W-1:0] p1_s2, p2_s2;
	logic v1_s1, v2_s2, v3_s3, neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_s1 <= start;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		dux_s1 <= ectri_pkg::DIFF_W'(a.x) - ectri_pkg::DIFF_W'(b.x);
		duy_s1 <= ectri_pkg::DIFF_W'(a.y) - ectri_pkg::DIFF_W'(b.y);
		dvx_s1 <= ectri_pkg::DIFF_W'(c.x) - ectri_pkg::DIFF_W'(b.x);
		dvy_s1 <= ectri_pkg::DIFF_W'(c.y) - ectri_pkg::DIFF_W'(b.y);
		p1_s2  <= ectri_pkg::PROD_W'(dux_s1) * ectri_pkg::PROD_W'(dvy_s1);
		p2_s2  <= ectri_pkg::PROD_W'(duy_s1) * ectri_pkg::PROD_W'(dvx_s1);
		neg_s3 <= p1_s2 < p2_s2;
	end

	assign done = v3_s3;
	assign neg  = neg_s3;
endmodule
`default_nettype wire

// File: rtl/ectri_inside.sv
// Pipelined point-in-triangle test over a stream of vertices, with a sticky hit flag.
// Depends on ectri_pkg.
`default_nettype none
module ectri_inside (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              clr,
	input  wire              q_valid,
	input  ectri_pkg::vtx_t  q,
	input  ectri_pkg::vtx_t  a,
	input  ectri_pkg::vtx_t  b,
	input  ectri_pkg::vtx_t  c,
	output logic             busy,
	output logic             hit
);
	logic signed [ectri_pkg::DIFF_W-1:0] acx_s1, acy_s1, bax_s1, bay_s1, cbx_s1, cby_s1;
	logic signed [ectri_pkg::DIFF_W-1:0] qcx_s1, qcy_s1, qax_s1, qay_s1, qbx_s1, qby_s1;
	logic signed [ectri_pkg::PROD_W-1:0] ps1_s2, ps2_s2, pt1_s2, pt2_s2, pd1_s2, pd2_s2;
	logic signed [ectri_pkg::CROSS_W-1:0] s_s3, t_s3, d_s3;
	logic signed [ectri_pkg::SUM_W-1:0] st;
	logic v1_s1, v2_s2, v3_s3, same_s1, same_s2, same_s3;
	logic hit_q, split, in_tri;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			v1_s1 <= q_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			if (clr) begin
				hit_q <= 1'b0;
			end else if (v3_s3 && !same_s3 && in_tri) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		acx_s1  <= ectri_pkg::DIFF_W'(a.x) - ectri_pkg::DIFF_W'(c.x);
		acy_s1  <= ectri_pkg::DIFF_W'(a.y) - ectri_pkg::DIFF_W'(c.y);
		bax_s1  <= ectri_pkg::DIFF_W'(b.x) - ectri_pkg::DIFF_W'(a.x);
		bay_s1  <= ectri_pkg::DIFF_W'(b.y) - ectri_pkg::DIFF_W'(a.y);
		cbx_s1  <= ectri_pkg::DIFF_W'(c.x) - ectri_pkg::DIFF_W'(b.x);
		cby_s1  <= ectri_pkg::DIFF_W'(c.y) - ectri_pkg::DIFF_W'(b.y);
		qcx_s1  <= ectri_pkg::DIFF_W'(q.x) - ectri_pkg::DIFF_W'(c.x);
		qcy_s1  <= ectri_pkg::DIFF_W'(q.y) - ectri_pkg::DIFF_W'(c.y);
		qax_s1  <= ectri_pkg::DIFF_W'(q.x) - ectri_pkg::DIFF_W'(a.x);
		qay_s1  <= ectri_pkg::DIFF_W'(q.y) - ectri_pkg::DIFF_W'(a.y);
		qbx_s1  <= ectri_pkg::DIFF_W'(q.x) - ectri_pkg::DIFF_W'(b.x);
		qby_s1  <= ectri_pkg::DIFF_W'(q.y) - ectri_pkg::DIFF_W'(b.y);
		same_s1 <= (q == a) || (q == b) || (q == c);

		ps1_s2  <= ectri_pkg::PROD_W'(acx_s1) * ectri_pkg::PROD_W'(qcy_s1);
		ps2_s2  <= ectri_pkg::PROD_W'(acy_s1) * ectri_pkg::PROD_W'(qcx_s1);
		pt1_s2  <= ectri_pkg::PROD_W'(bax_s1) * ectri_pkg::PROD_W'(qay_s1);
		pt2_s2  <= ectri_pkg::PROD_W'(bay_s1) * ectri_pkg::PROD_W'(qax_s1);
		pd1_s2  <= ectri_pkg::PROD_W'(cbx_s1) * ectri_pkg::PROD_W'(qby_s1);
		pd2_s2  <= ectri_pkg::PROD_W'(cby_s1) * ectri_pkg::PROD_W'(qbx_s1);
		same_s2 <= same_s1;

		s_s3    <= ectri_pkg::CROSS_W'(ps1_s2) - ectri_pkg::CROSS_W'(ps2_s2);
		t_s3    <= ectri_pkg::CROSS_W'(pt1_s2) - ectri_pkg::CROSS_W'(pt2_s2);
		d_s3    <= ectri_pkg::CROSS_W'(pd1_s2) - ectri_pkg::CROSS_W'(pd2_s2);
		same_s3 <= same_s2;
	end

	// s and t of opposite strict sign put the point outside
	always_comb begin
		st     = ectri_pkg::SUM_W'(s_s3) + ectri_pkg::SUM_W'(t_s3);
		split  = ((s_s3 < 0) != (t_s3 < 0)) && (s_s3 != 0) && (t_s3 != 0);
		in_tri = !split && ((d_s3 == 0) || ((d_s3 < 0) == (st <= 0)));
	end

	assign busy = v1_s1 | v2_s2 | v3_s3;
	assign hit  = hit_q;
endmodule
`default_nettype wire

// File: rtl/ear_clipping_triangulator_core.sv
// Ear clipping core: one vertex item per cycle while loading; the item with tlast set starts
// triangulation (under three vertices, an ST_FEW item) and holds the input off until the last
// result has entered the output register. Steps: winding scan, winding turn test, ring set-up,
// pass start; each candidate ear is fetched, turn-tested, decided and advanced past, plus the
// inside test on a convex corner and any wait for the receiver. Results leave through a one-deep
// pending stage and the output register. Reset (arst_n, asynchronous) empties the store.
`default_nettype none
module ear_clipping_triangulator_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // vertex_x [15:0], vertex_y [31:16]
	input  wire         s_tlast,   // last_vertex
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata,   // tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy
	output logic [2:0]  m_tuser,   // has_triangle [0], status [2:1]
	output logic        m_tlast    // last_result
);
	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_WSCAN  = 4'd1;
	localparam logic [3:0] S_FETCH  = 4'd2;
	localparam logic [3:0] S_TURN   = 4'd3;
	localparam logic [3:0] S_INIT   = 4'd4;
	localparam logic [3:0] S_PSTART = 4'd5;
	localparam logic [3:0] S_TEST   = 4'd6;
	localparam logic [3:0] S_DECIDE = 4'd7;
	localparam logic [3:0] S_ADV    = 4'd8;
	localparam logic [3:0] S_PUSHF  = 4'd9;
	localparam logic [3:0] S_FAIL   = 4'd10;
	localparam logic [3:0] S_FLUSH  = 4'd11;

	localparam logic [1:0] M_WIND  = 2'd0;
	localparam logic [1:0] M_CAND  = 2'd1;
	localparam logic [1:0] M_FINAL = 2'd2;

	localparam int IW = ectri_pkg::IDX_W;
	localparam int CW = ectri_pkg::CNT_W;

	// Vertex store and the next-pointer ring of the live polygon
	ectri_pkg::vtx_t vmem [ectri_pkg::MAX_VERTICES];
	logic [IW-1:0]   nmem [ectri_pkg::MAX_VERTICES];

	logic [3:0]      state_q;
	logic [1:0]      mode_q, step_q;
	logic [CW-1:0]   cnt_q, n_q, live_cnt_q, sp_q, j_q;
	logic            ovf_q, seen_q, rev_q, ear_q, rem_q, bvalid_q;
	logic [IW-1:0]   head_q, ia_q, ib_q, ic_q, best_q, rd_idx_q, nrd_q;
	ectri_pkg::vtx_t best_v_q, va_q, vb_q, vc_q, vrd_q;
	logic [ectri_pkg::MAX_VERTICES-1:0] live_q;
	logic            rd_v_q;
	ectri_pkg::res_t pend_q, out_q;
	logic            pend_v_q, out_v_q;

	logic            acc, out_free, can_push, push, flush, issue, vwe, nwe;
	logic            turn_start, turn_done, turn_neg, clr_in, q_valid, in_busy, in_hit;
	logic            better, ear_fire, more;
	logic [CW-1:0]   nn, live_nx, nxt_i, prv_i;
	logic [IW-1:0]   vaddr, naddr, nwa, nwd, prev_b, next_b;
	logic [1:0]      tri_st;
	ectri_pkg::res_t push_d, tri_r, fail_r, few_r, fin_r;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = (state_q == S_LOAD);
	assign out_free = !out_v_q || m_tready;
	assign can_push = !pend_v_q || out_free;
	assign tri_st   = ovf_q ? ectri_pkg::ST_OVF : ectri_pkg::ST_OK;
	assign nn       = cnt_q[CW-1] ? cnt_q : cnt_q + CW'(1);

	// Winding neighbours of the leftmost (topmost on a tie) vertex
	assign prev_b = (best_q == '0) ? IW'(n_q - CW'(1)) : best_q - IW'(1);
	assign next_b = ({1'b0, best_q} + CW'(1) == n_q) ? '0 : best_q + IW'(1);
	assign better = !bvalid_q || (vrd_q.x < best_v_q.x) ||
		((vrd_q.x == best_v_q.x) && (vrd_q.y > best_v_q.y));

	// Ring links for set-up, forward or reversed
	assign nxt_i = (j_q + CW'(1) == n_q) ? '0 : j_q + CW'(1);
	assign prv_i = (j_q == '0) ? n_q - CW'(1) : j_q - CW'(1);

	always_comb begin
		tri_r         = '0;
		tri_r.a       = va_q;
		tri_r.b       = vb_q;
		tri_r.c       = vc_q;
		tri_r.has_tri = 1'b1;
		tri_r.status  = tri_st;
		fail_r        = '0;
		fail_r.status = ectri_pkg::ST_NO_EAR;
		few_r         = '0;
		few_r.status  = ectri_pkg::ST_FEW;
		fin_r         = pend_q;
		fin_r.last    = 1'b1;
	end

	assign ear_fire = (state_q == S_DECIDE) && ear_q && can_push;
	assign live_nx  = ear_fire ? live_cnt_q - CW'(1) : live_cnt_q;
	assign more     = (sp_q + CW'(1)) < live_nx;

	always_comb begin
		vaddr      = '0;
		naddr      = '0;
		nwe        = 1'b0;
		nwa        = '0;
		nwd        = '0;
		vwe        = 1'b0;
		issue      = 1'b0;
		push       = 1'b0;
		push_d     = tri_r;
		flush      = 1'b0;
		turn_start = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				vwe = acc && !cnt_q[CW-1];
			end
			S_WSCAN, S_TEST: begin
				vaddr = j_q[IW-1:0];
				issue = j_q < n_q;
			end
			S_FETCH: begin
				unique case (step_q)
					2'd0:    vaddr = ia_q;
					2'd1:    vaddr = ib_q;
					default: vaddr = ic_q;
				endcase
			end
			S_TURN: begin
				turn_start = (step_q == 2'd0);
			end
			S_INIT: begin
				nwe = 1'b1;
				nwa = j_q[IW-1:0];
				nwd = rev_q ? prv_i[IW-1:0] : nxt_i[IW-1:0];
			end
			S_PSTART: begin
				naddr = (step_q == 2'd0) ? head_q : nrd_q;
			end
			S_DECIDE: begin
				push = ear_fire;
				nwe  = ear_fire;
				nwa  = ia_q;
				nwd  = ic_q;
			end
			S_ADV: begin
				naddr = (step_q == 2'd0) ? ic_q : nrd_q;
			end
			S_PUSHF: begin
				push = can_push;
			end
			S_FAIL: begin
				push   = can_push;
				push_d = fail_r;
			end
			S_FLUSH: begin
				flush = out_free;
			end
			default: begin
			end
		endcase
	end

	// Memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[cnt_q[IW-1:0]] <= ectri_pkg::vtx_t'({s_tdata[31:16], s_tdata[15:0]});
		end
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (nwe) begin
			nmem[nwa] <= nwd;
		end
		nrd_q <= nmem[naddr];
	end

	assign clr_in  = (state_q == S_TURN) && turn_done;
	assign q_valid = (state_q == S_TEST) && rd_v_q && live_q[rd_idx_q];

	ectri_turn u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (turn_start),
		.a      (va_q),
		.b      (vb_q),
		.c      (vc_q),
		.done   (turn_done),
		.neg    (turn_neg)
	);

	ectri_inside u_inside (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr_in),
		.q_valid (q_valid),
		.q       (vrd_q),
		.a       (va_q),
		.b       (vb_q),
		.c       (vc_q),
		.busy    (in_busy),
		.hit     (in_hit)
	);

	// Output register; the pending stage holds one result back until its last flag is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((push && pend_v_q) || flush) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			out_q <= fin_r;
		end else if (push && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.c.y, out_q.c.x, out_q.b.y, out_q.b.x, out_q.a.y, out_q.a.x};
	assign m_tuser  = {out_q.status, out_q.has_tri};
	assign m_tlast  = out_q.last;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			mode_q     <= M_WIND;
			step_q     <= '0;
			cnt_q      <= '0;
			n_q        <= '0;
			live_cnt_q <= '0;
			sp_q       <= '0;
			j_q        <= '0;
			ovf_q      <= 1'b0;
			seen_q     <= 1'b0;
			rev_q      <= 1'b0;
			ear_q      <= 1'b0;
			rem_q      <= 1'b0;
			bvalid_q   <= 1'b0;
			head_q     <= '0;
			ia_q       <= '0;
			ib_q       <= '0;
			ic_q       <= '0;
			best_q     <= '0;
			rd_idx_q   <= '0;
			rd_v_q     <= 1'b0;
			live_q     <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			rd_v_q   <= issue;
			rd_idx_q <= j_q[IW-1:0];
			if (push) begin
				pend_q   <= push_d;
				pend_v_q <= 1'b1;
			end
			if (flush) begin
				pend_v_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (!cnt_q[CW-1]) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q    <= nn;
							j_q    <= '0;
							if (nn < CW'(3)) begin
								pend_q   <= few_r;
								pend_v_q <= 1'b1;
								state_q  <= S_FLUSH;
							end else begin
								bvalid_q <= 1'b0;
								state_q  <= S_WSCAN;
							end
						end
					end
				end
				S_WSCAN: begin
					if (issue) begin
						j_q <= j_q + CW'(1);
					end
					if (rd_v_q && better) begin
						best_q   <= rd_idx_q;
						best_v_q <= vrd_q;
						bvalid_q <= 1'b1;
					end
					if (j_q == n_q && !rd_v_q) begin
						// turn test at the extreme vertex: a=best, b=prev, c=next
						ia_q    <= best_q;
						ib_q    <= prev_b;
						ic_q    <= next_b;
						mode_q  <= M_WIND;
						step_q  <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					step_q <= step_q + 2'd1;
					unique case (step_q)
						2'd0: begin
						end
						2'd1: va_q <= vrd_q;
						2'd2: vb_q <= vrd_q;
						default: begin
							vc_q    <= vrd_q;
							step_q  <= '0;
							state_q <= (mode_q == M_FINAL) ? S_PUSHF : S_TURN;
						end
					endcase
				end
				S_TURN: begin
					step_q <= 2'd1;
					if (turn_done) begin
						j_q    <= '0;
						step_q <= '0;
						if (mode_q == M_WIND) begin
							rev_q   <= turn_neg;
							state_q <= S_INIT;
						end else if (turn_neg) begin
							state_q <= S_TEST;
						end else begin
							ear_q   <= 1'b0;
							state_q <= S_DECIDE;
						end
					end
				end
				S_INIT: begin
					j_q            <= j_q + CW'(1);
					live_q[nwa]    <= 1'b1;
					if (j_q == n_q - CW'(1)) begin
						head_q     <= rev_q ? IW'(n_q - CW'(1)) : '0;
						live_cnt_q <= n_q;
						step_q     <= '0;
						state_q    <= S_PSTART;
					end
				end
				S_PSTART: begin
					unique case (step_q)
						2'd0: begin
							ia_q   <= head_q;
							step_q <= 2'd1;
							if (live_cnt_q > CW'(3)) begin
								seen_q <= 1'b0;
								sp_q   <= CW'(1);
								mode_q <= M_CAND;
							end else if (live_cnt_q == CW'(3)) begin
								mode_q <= M_FINAL;
							end else begin
								// pass left two vertices: close with what is pending
								state_q <= S_FLUSH;
							end
						end
						2'd1: begin
							ib_q   <= nrd_q;
							step_q <= 2'd2;
						end
						default: begin
							ic_q    <= nrd_q;
							step_q  <= '0;
							state_q <= S_FETCH;
						end
					endcase
				end
				S_TEST: begin
					if (issue) begin
						j_q <= j_q + CW'(1);
					end
					if (j_q == n_q && !rd_v_q && !in_busy) begin
						ear_q   <= !in_hit;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!ear_q || can_push) begin
						if (ear_fire) begin
							live_q[ib_q] <= 1'b0;
							live_cnt_q   <= live_nx;
							seen_q       <= 1'b1;
						end
						sp_q   <= sp_q + CW'(1);
						rem_q  <= ear_fire;
						step_q <= '0;
						if (more) begin
							state_q <= S_ADV;
						end else if (seen_q || ear_fire) begin
							state_q <= S_PSTART;
						end else begin
							state_q <= S_FAIL;
						end
					end
				end
				S_ADV: begin
					unique case (step_q)
						2'd0: step_q <= 2'd1;
						2'd1: begin
							if (rem_q) begin
								// skip the vertex that slid into the clipped slot
								ia_q   <= ic_q;
								ib_q   <= nrd_q;
								step_q <= 2'd2;
							end else begin
								ia_q    <= ib_q;
								ib_q    <= ic_q;
								ic_q    <= nrd_q;
								step_q  <= '0;
								state_q <= S_FETCH;
							end
						end
						default: begin
							ic_q    <= nrd_q;
							step_q  <= '0;
							state_q <= S_FETCH;
						end
					endcase
				end
				S_PUSHF, S_FAIL: begin
					if (can_push) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/ectri_checker.sv
// Port-level checks of the ear clipping core, bound to its top level.
// Depends on ectri_pkg and ear_clipping_triangulator_core_defines.svh.
`default_nettype none
`include "ear_clipping_triangulator_core_defines.svh"
module ectri_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] s_tdata,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata,
	input wire [2:0]  m_tuser,
	input wire        m_tlast
);
	`ECT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`ECT_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
	`ECT_ASSERT_NOW(a_status_is_last, m_tvalid && !m_tuser[0], m_tlast)
	`ECT_ASSERT_NOW(a_tri_status, m_tvalid && m_tuser[0], (m_tuser[2:1] == ectri_pkg::ST_OK) || (m_tuser[2:1] == ectri_pkg::ST_OVF))
endmodule

bind ear_clipping_triangulator_core ectri_checker u_ectri_checker (.*);
`default_nettype wire

// File: sim/ear_clipping_triangulator_core_tb.sv
// Self-checking bench for the ear clipping core: directed rows, then random polygons.
// Predicts each triangle and status item on its own, but for the hand-checked rows; depends on ectri_pkg and the core.
`default_nettype none
module ear_clipping_triangulator_core_tb;

	localparam int RANDOM_ITEMS = 230;
	localparam int RESULT_CAP   = 62;
	localparam int IDLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES  = 2500;

	typedef struct {
		longint x;
		longint y;
	} pt_t;

	// one predicted or hand-written result item
	typedef struct {
		logic [5:0][15:0] cor;   // ax, ay, bx, by, cx, cy from index 0 up
		logic             has;
		logic [1:0]       st;
		logic             last;
	} tri_item_t;

	// one vertex item; hand_res applies to the closing vertex of a hand-checked polygon
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		bit                 by_hand;
		bit                 pause;
		tri_item_t          hand_res;
	} vertex_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	vertex_item_t vertex_list[$];
	tri_item_t    pending_tris[$];
	pt_t          open_poly[$];
	bit           open_ovf;
	int           n_errors, n_in, n_out, n_polys, n_tris, n_no_ear, n_few, n_ovf;
	int           quiet_cycles;
	bit           calm;
	bit           feed_done;
	bit           hold_done;

	ear_clipping_triangulator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("mismatch at result %0d: %s got %0h want %0h", n_out, what, got, want);
	endtask

	function automatic longint cross3(pt_t a, pt_t b, pt_t c);
		return (a.x - b.x) * (c.y - b.y) - (a.y - b.y) * (c.x - b.x);
	endfunction

	function automatic bit same_pt(pt_t a, pt_t b);
		return a.x == b.x && a.y == b.y;
	endfunction

	// point in triangle, edges counting as inside
	function automatic bit covers(pt_t a, pt_t b, pt_t c, pt_t q);
		longint s, t, d;
		s = (a.x - c.x) * (q.y - c.y) - (a.y - c.y) * (q.x - c.x);
		t = (b.x - a.x) * (q.y - a.y) - (b.y - a.y) * (q.x - a.x);
		if (((s < 0) != (t < 0)) && s != 0 && t != 0)
			return 1'b0;
		d = (c.x - b.x) * (q.y - b.y) - (c.y - b.y) * (q.x - b.x);
		return d == 0 || ((d < 0) == (s + t <= 0));
	endfunction

	function automatic bit is_clippable(pt_t ring[$], int live, pt_t a, pt_t b, pt_t c);
		if (cross3(a, b, c) >= 0)
			return 1'b0;
		for (int j = 0; j < live; j++) begin
			if (same_pt(ring[j], a) || same_pt(ring[j], b) || same_pt(ring[j], c))
				continue;
			if (covers(a, b, c, ring[j]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void queue_tri(inout int k, input pt_t a, input pt_t b, input pt_t c,
			input bit has, input logic [1:0] st);
		tri_item_t r;
		if (k >= RESULT_CAP)
			return;
		r.cor  = '0;
		if (has)
			r.cor = {c.y[15:0], c.x[15:0], b.y[15:0], b.x[15:0], a.y[15:0], a.x[15:0]};
		r.has  = has;
		r.st   = st;
		r.last = 1'b0;
		pending_tris.insert(pending_tris.size(), r);
		k++;
	endfunction

	// work out every result item of one closed polygon
	function automatic void clip_polygon(input pt_t pts[$], input bit ovf);
		pt_t        ring[$];
		pt_t        zero_pt;
		int         n, best, prv, nxt, live, k;
		bit         seen, fail;
		logic [1:0] st;
		k       = 0;
		zero_pt = '{0, 0};
		n       = pts.size();
		st      = ovf ? ectri_pkg::ST_OVF : ectri_pkg::ST_OK;
		fail    = 1'b0;
		if (n < 3) begin
			queue_tri(k, zero_pt, zero_pt, zero_pt, 1'b0, ectri_pkg::ST_FEW);
		end else begin
			best = 0;
			for (int i = 1; i < n; i++)
				if (pts[i].x < pts[best].x || (pts[i].x == pts[best].x && pts[i].y > pts[best].y))
					best = i;
			prv = (best == 0) ? n - 1 : best - 1;
			nxt = (best + 1 == n) ? 0 : best + 1;
			// reverse a clockwise outline so the ring always runs counter-clockwise
			if ((pts[best].x - pts[prv].x) * (pts[nxt].y - pts[prv].y) -
					(pts[nxt].x - pts[prv].x) * (pts[best].y - pts[prv].y) < 0) begin
				for (int i = n - 1; i >= 0; i--)
					ring.insert(ring.size(), pts[i]);
			end else begin
				ring = pts;
			end
			live = n;
			while (live > 3 && !fail) begin
				seen = 1'b0;
				// scan goes on after a removal, skipping the vertex that slid down
				for (int pos = 1; pos < live; pos++) begin
					pt_t c;
					c = (pos + 1 == live) ? ring[0] : ring[pos + 1];
					if (is_clippable(ring, live, ring[pos - 1], ring[pos], c)) begin
						queue_tri(k, ring[pos - 1], ring[pos], c, 1'b1, st);
						ring.delete(pos);
						live--;
						seen = 1'b1;
					end
				end
				if (!seen)
					fail = 1'b1;
			end
			if (fail)
				queue_tri(k, zero_pt, zero_pt, zero_pt, 1'b0, ectri_pkg::ST_NO_EAR);
			else if (live == 3)
				queue_tri(k, ring[0], ring[1], ring[2], 1'b1, st);
		end
		if (k > 0)
			pending_tris[$].last = 1'b1;
	endfunction

	function automatic void add_vertex(input int x, input int y, input bit last);
		vertex_item_t v;
		v          = '{default: '0};
		v.x        = x[15:0];
		v.y        = y[15:0];
		v.last     = last;
		vertex_list.insert(vertex_list.size(), v);
	endfunction

	// angular order around the centre, used to build simple star-shaped outlines
	function automatic bit precedes(pt_t a, pt_t b);
		bit ha, hb;
		ha = (a.y < 0) || (a.y == 0 && a.x < 0);
		hb = (b.y < 0) || (b.y == 0 && b.x < 0);
		if (ha != hb)
			return hb;
		return a.x * b.y - a.y * b.x > 0;
	endfunction

	function automatic void add_star(input int n, input int spread, input bit pause_first);
		pt_t off[$];
		pt_t p;
		int  cx, cy, at;
		bit  cw;
		cx = $urandom_range(0, 40000) - 20000;
		cy = $urandom_range(0, 40000) - 20000;
		cw = $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			p.x = longint'($urandom_range(0, 2 * spread)) - spread;
			p.y = longint'($urandom_range(0, 2 * spread)) - spread;
			at  = off.size();
			for (int j = 0; j < off.size(); j++)
				if (precedes(p, off[j])) begin
					at = j;
					break;
				end
			off.insert(at, p);
		end
		for (int i = 0; i < n; i++) begin
			p = cw ? off[n - 1 - i] : off[i];
			add_vertex(cx + int'(p.x), cy + int'(p.y), i == n - 1);
			if (i == 0)
				vertex_list[$].pause = pause_first;
		end
	endfunction

	function automatic void add_noise(input int n);
		for (int i = 0; i < n; i++)
			add_vertex($urandom_range(0, 65535), $urandom_range(0, 65535), i == n - 1);
	endfunction

	// directed rows; closing rows of the under-three and collinear cases carry their result
	function automatic void build_directed();
		tri_item_t few_res, no_ear_res;
		few_res    = '{cor: '0, has: 1'b0, st: ectri_pkg::ST_FEW, last: 1'b1};
		no_ear_res = '{cor: '0, has: 1'b0, st: ectri_pkg::ST_NO_EAR, last: 1'b1};
		add_vertex(-32768, 32767, 1'b1);
		vertex_list[$].by_hand  = 1'b1;
		vertex_list[$].hand_res = few_res;
		add_vertex(32767, -32768, 1'b0);
		add_vertex(0, 0, 1'b1);
		vertex_list[$].by_hand  = 1'b1;
		vertex_list[$].hand_res = few_res;
		add_vertex(-32768, -32768, 1'b0);
		add_vertex(32767, -32768, 1'b0);
		add_vertex(0, 32767, 1'b1);
		add_vertex(0, 0, 1'b0);
		add_vertex(0, 100, 1'b0);
		add_vertex(100, 0, 1'b1);
		add_vertex(0, 0, 1'b0);
		add_vertex(1, 1, 1'b0);
		add_vertex(2, 2, 1'b0);
		add_vertex(3, 3, 1'b1);
		vertex_list[$].by_hand  = 1'b1;
		vertex_list[$].hand_res = no_ear_res;
		add_vertex(0, 0, 1'b0);
		add_vertex(10, 0, 1'b0);
		add_vertex(10, 10, 1'b0);
		add_vertex(5, 3, 1'b0);
		add_vertex(0, 10, 1'b1);
		add_vertex(32767, 32767, 1'b0);
		add_vertex(-32768, 32767, 1'b0);
		add_vertex(-32768, -32768, 1'b0);
		add_vertex(32767, -32768, 1'b1);
	endfunction

	function automatic void build_random();
		int start, pick;
		bit big_done, ovf_done, paused;
		start    = vertex_list.size();
		big_done = 1'b0;
		ovf_done = 1'b0;
		paused   = 1'b0;
		while (vertex_list.size() - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!big_done && vertex_list.size() - start > 60) begin
				add_star(64, 12000, 1'b0);
				big_done = 1'b1;
			end else if (!ovf_done && vertex_list.size() - start > 140) begin
				add_star(66, 12000, 1'b0);
				ovf_done = 1'b1;
			end else if (pick < 70) begin
				add_star($urandom_range(3, 10), $urandom_range(2, 12000),
					!paused && vertex_list.size() - start > 100);
				if (vertex_list.size() - start > 100)
					paused = 1'b1;
			end else if (pick < 90) begin
				add_noise($urandom_range(3, 8));
			end else begin
				add_noise($urandom_range(1, 2));
			end
		end
	endfunction

	// sender: one item per handshake, random gaps, a pause to drain once
	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		calm      = 1'b0;
		feed_done = 1'b0;
		build_directed();
		build_random();
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		foreach (vertex_list[i]) begin
			calm = i > (vertex_list.size() * 17) / 20;
			if (vertex_list[i].pause) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_tris.size() != 0)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {vertex_list[i].y, vertex_list[i].x};
			s_tlast  <= vertex_list[i].last;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		s_tvalid  <= 1'b0;
		feed_done = 1'b1;
	end

	// receiver: one long hold-off once the sender is well under way, then random stalls
	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		forever begin
			if (!hold_done && n_in > 40) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20))
					@(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
	end

	// capture accepted vertices, predict on the closing one, check every result item
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (open_poly.size() < ectri_pkg::MAX_VERTICES)
					open_poly.insert(open_poly.size(), '{longint'($signed(s_tdata[15:0])),
						longint'($signed(s_tdata[31:16]))});
				else
					open_ovf = 1'b1;
				if (s_tlast) begin
					if (vertex_list[n_in].by_hand)
						pending_tris.insert(pending_tris.size(), vertex_list[n_in].hand_res);
					else
						clip_polygon(open_poly, open_ovf);
					open_poly.delete();
					open_ovf = 1'b0;
					n_polys++;
				end
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				if (pending_tris.size() == 0) begin
					report_mismatch("unexpected result item, user", {29'd0, m_tuser}, '0);
				end else begin
					tri_item_t want;
					want = pending_tris.pop_front();
					for (int f = 0; f < 6; f++)
						if (m_tdata[16 * f +: 16] !== want.cor[f])
							report_mismatch($sformatf("corner field %0d", f),
								m_tdata[16 * f +: 16], want.cor[f]);
					if (m_tuser[0] !== want.has)
						report_mismatch("has_triangle", m_tuser[0], want.has);
					if (m_tuser[2:1] !== want.st)
						report_mismatch("status", m_tuser[2:1], want.st);
					if (m_tlast !== want.last)
						report_mismatch("last_result", m_tlast, want.last);
					if (want.has)
						n_tris++;
					else if (want.st == ectri_pkg::ST_NO_EAR)
						n_no_ear++;
					else
						n_few++;
					if (want.has && want.st == ectri_pkg::ST_OVF)
						n_ovf++;
				end
				n_out++;
			end
		end
	end

	// watchdog: give up after a long stretch in which no item moves on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		open_ovf = 1'b0;
		n_errors = 0;
		n_in     = 0;
		n_out    = 0;
		n_polys  = 0;
		n_tris   = 0;
		n_no_ear = 0;
		n_few    = 0;
		n_ovf    = 0;
		@(posedge clk);
		while (!feed_done)
			@(posedge clk);
		while (pending_tris.size() != 0)
			@(posedge clk);
		// drain: anything arriving now has no expectation and is flagged above
		repeat (500)
			@(posedge clk);
		$display("covered %0d vertices in %0d polygons: %0d triangles (%0d overflow-tagged),",
			n_in, n_polys, n_tris, n_ovf);
		$display("  %0d no-ear and %0d under-three reports, %0d result items in all",
			n_no_ear, n_few, n_out);
		if (n_errors == 0 && pending_tris.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
